// ===== hw/rtl/e2c_pkg.sv =====
package e2c_pkg;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DDAY = 9'b000000010,
        S_DHR  = 9'b000000100,
        S_DMIN = 9'b000001000,
        S_CENT = 9'b000010000,
        S_LMOD = 9'b000100000,
        S_YEAR = 9'b001000000,
        S_MON  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    localparam logic [17:0] DIV_DAY  = 18'd86400;
    localparam logic [17:0] DIV_HOUR = 18'd3600;
    localparam logic [17:0] DIV_MIN  = 18'd60;

    // reciprocals, rounded up; exact over the input ranges used below
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;  // ceil(2^35 / 675)
    localparam logic [13:0] RECIP_HOUR = 14'd9321;      // ceil(2^21 / 225)
    localparam logic [10:0] RECIP_MIN  = 11'd1093;      // ceil(2^14 / 15)

    localparam logic [8:0]  DAYS_YEAR     = 9'd365;
    localparam logic [11:0] BASE_YEAR_RST = 12'd1970;
    localparam logic [11:0] YEAR_LAST     = 12'hFFF;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // floor(s / 86400) as floor(floor(s / 128) / 675)
    function automatic logic [15:0] days_of(input logic [31:0] s);
        logic [50:0] prod;
        prod = 51'(s[31:7]) * 51'(RECIP_DAY);
        return prod[50:35];
    endfunction

    // floor(tod / 3600) as floor(floor(tod / 16) / 225), tod < 86400
    function automatic logic [4:0] hour_of(input logic [16:0] tod);
        logic [25:0] prod;
        prod = 26'(tod[16:4]) * 26'(RECIP_HOUR);
        return prod[25:21];
    endfunction

    // floor(r / 60) as floor(floor(r / 4) / 15), r < 3600
    function automatic logic [5:0] minute_of(input logic [11:0] r);
        logic [19:0] prod;
        prod = 20'(r[11:2]) * 20'(RECIP_MIN);
        return prod[19:14];
    endfunction

    // floor(y / 100) as floor((y >> 2) / 25); 1311 / 2^15 is exact enough for 10 bits
    function automatic logic [5:0] century_of(input logic [11:0] y);
        logic [20:0] prod;
        prod = 21'(y[11:2]) * 21'd1311;
        return prod[20:15];
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = MONTH_LEN[m - 4'd1];
        if (m == MONTH_FEB && leap) begin
            len = len + 5'd1;
        end
        return len;
    endfunction

endpackage

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// Seconds count to Gregorian date and time of day.
//
// Input channel: i_valid / o_stall carry one word, i_epoch_seconds, the
// number of seconds since 00:00:00 on 1 January of the base year. A word is
// taken when i_valid is high and o_stall is low; o_stall is high for the
// whole time a conversion runs.
// Output channel: o_valid / i_stall carry year, month, day, hour, minute
// and second. The result sits in an output register, so the next input word
// is taken while an earlier result still waits for the receiver.
// Base year: written by the user through i_cfg_wr_en / i_cfg_wr_data, only
// while idle, which the block itself does not enforce.
//
// Steps: day, hour and minute come from reciprocal multiplies, each as a quotient
// step then a remainder step (S_DDAY, S_DHR, S_DMIN); leap-year set-up in S_CENT
// then S_LMOD; one shared subtractor walks the years (up to 136 stepped over) in
// S_YEAR and the months in S_MON, and S_DONE loads the output. A new word is
// taken only once the last result has gone into the output register.
// Reset (i_rst_n low, synchronous) empties the output, returns to idle and
// sets the base year to 1970. While the receiver stalls a finished result,
// the sequencer holds in its last state until the output register frees.
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [11:0] i_cfg_wr_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_epoch_seconds,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    e2c_pkg::t_state r_state, n_state;
    logic        r_cnt,   n_cnt;      // division phase: quotient (1), then remainder (0)
    logic [31:0] r_num,   n_num;      // seconds count of the word in hand
    logic [16:0] r_rem,   n_rem;      // seconds left after the last quotient
    logic [15:0] r_days,  n_days;     // whole days left to place
    logic [4:0]  r_hour,  n_hour;
    logic [5:0]  r_min,   n_min;
    logic [5:0]  r_sec,   n_sec;
    logic [11:0] r_year,  n_year;
    logic [5:0]  r_cent,  n_cent;     // floor(year / 100)
    logic [6:0]  r_m100,  n_m100;     // year mod 100
    logic [8:0]  r_m400,  n_m400;     // year mod 400
    logic [3:0]  r_month, n_month;
    logic [11:0] r_base,  n_base;
    logic        r_o_valid, n_o_valid;
    logic        w_load;

    logic [11:0] r_o_year;
    logic [3:0]  r_o_month;
    logic [4:0]  r_o_day;
    logic [4:0]  r_o_hour;
    logic [5:0]  r_o_min;
    logic [5:0]  r_o_sec;

    // ---------------------------------------------------------------
    // shared subtract / compare unit
    // ---------------------------------------------------------------
    logic [15:0] w_a, w_b;
    logic [16:0] w_diff;
    logic        w_fits;     // a >= b
    logic        w_leap;
    logic [4:0]  w_mlen;

    // leap rule from the tracked residues: mod 4 is the low bits
    assign w_leap = (r_year[1:0] == 2'd0) && ((r_m100 != 7'd0) || (r_m400 == 9'd0));
    assign w_mlen = e2c_pkg::month_len(r_month, w_leap);

    always_comb begin
        case (r_state)
            e2c_pkg::S_YEAR: begin
                w_a = r_days;
                w_b = 16'(e2c_pkg::DAYS_YEAR) + 16'(w_leap);
            end
            e2c_pkg::S_MON: begin
                w_a = r_days;
                w_b = 16'(w_mlen);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_diff = {1'b0, w_a} - {1'b0, w_b};
    assign w_fits = ~w_diff[16];

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign w_load = (r_state == e2c_pkg::S_DONE) && (!r_o_valid || !i_stall);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_num     = r_num;
        n_rem     = r_rem;
        n_days    = r_days;
        n_hour    = r_hour;
        n_min     = r_min;
        n_sec     = r_sec;
        n_year    = r_year;
        n_cent    = r_cent;
        n_m100    = r_m100;
        n_m400    = r_m400;
        n_month   = r_month;
        n_base    = i_cfg_wr_en ? i_cfg_wr_data : r_base;
        n_o_valid = r_o_valid && i_stall;

        case (r_state)
            e2c_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_num   = i_epoch_seconds;
                    n_cnt   = 1'b1;
                    n_year  = r_base;
                    n_state = e2c_pkg::S_DDAY;
                end
            end
            e2c_pkg::S_DDAY: begin
                if (r_cnt) begin
                    n_days = e2c_pkg::days_of(r_num);
                    n_cnt  = 1'b0;
                end else begin
                    // second of day, below 86400
                    n_rem   = 17'(r_num - 32'(r_days) * 32'(e2c_pkg::DIV_DAY));
                    n_cnt   = 1'b1;
                    n_state = e2c_pkg::S_DHR;
                end
            end
            e2c_pkg::S_DHR: begin
                if (r_cnt) begin
                    n_hour = e2c_pkg::hour_of(r_rem);
                    n_cnt  = 1'b0;
                end else begin
                    // second of hour, below 3600
                    n_rem   = r_rem - 17'(r_hour) * 17'(e2c_pkg::DIV_HOUR);
                    n_cnt   = 1'b1;
                    n_state = e2c_pkg::S_DMIN;
                end
            end
            e2c_pkg::S_DMIN: begin
                if (r_cnt) begin
                    n_min = e2c_pkg::minute_of(r_rem[11:0]);
                    n_cnt = 1'b0;
                end else begin
                    n_sec   = 6'(r_rem - 17'(r_min) * 17'(e2c_pkg::DIV_MIN));
                    n_state = e2c_pkg::S_CENT;
                end
            end
            e2c_pkg::S_CENT: begin
                n_cent  = e2c_pkg::century_of(r_year);
                n_state = e2c_pkg::S_LMOD;
            end
            e2c_pkg::S_LMOD: begin
                n_m100  = 7'(r_year - 12'(r_cent) * 12'd100);
                n_m400  = 9'(r_year - 12'(r_cent[5:2]) * 12'd400);
                n_state = e2c_pkg::S_YEAR;
            end
            e2c_pkg::S_YEAR: begin
                if (w_fits) begin
                    n_days = w_diff[15:0];
                    if (r_year == e2c_pkg::YEAR_LAST) begin
                        // counter wraps to year 0: residues restart too
                        n_year = '0;
                        n_m100 = '0;
                        n_m400 = '0;
                    end else begin
                        n_year = r_year + 12'd1;
                        n_m100 = (r_m100 == 7'd99)  ? 7'd0 : r_m100 + 7'd1;
                        n_m400 = (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
                    end
                end else begin
                    n_month = e2c_pkg::MONTH_JAN;
                    n_state = e2c_pkg::S_MON;
                end
            end
            e2c_pkg::S_MON: begin
                if (r_month == e2c_pkg::MONTH_DEC || !w_fits) begin
                    n_state = e2c_pkg::S_DONE;
                end else begin
                    n_days  = w_diff[15:0];
                    n_month = r_month + 4'd1;
                end
            end
            e2c_pkg::S_DONE: begin
                if (w_load) begin
                    n_o_valid = 1'b1;
                    n_state   = e2c_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = e2c_pkg::S_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= e2c_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            r_base    <= e2c_pkg::BASE_YEAR_RST;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_base    <= n_base;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_days  <= n_days;
        r_hour  <= n_hour;
        r_min   <= n_min;
        r_sec   <= n_sec;
        r_year  <= n_year;
        r_cent  <= n_cent;
        r_m100  <= n_m100;
        r_m400  <= n_m400;
        r_month <= n_month;
        if (w_load) begin
            r_o_year  <= r_year;
            r_o_month <= r_month;
            r_o_day   <= r_days[4:0] + 5'd1;
            r_o_hour  <= r_hour;
            r_o_min   <= r_min;
            r_o_sec   <= r_sec;
        end
    end

    assign o_stall        = (r_state != e2c_pkg::S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_year         = r_o_year;
    assign o_month        = r_o_month;
    assign o_day_of_month = r_o_day;
    assign o_hour         = r_o_hour;
    assign o_minute       = r_o_min;
    assign o_second       = r_o_sec;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == e2c_pkg::S_DDAY))
        else $error("accepted word did not start the day division");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == e2c_pkg::S_MON) |-> (r_month >= 4'd1 && r_month <= e2c_pkg::MONTH_DEC))
        else $error("month walk out of range");

    a_residues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == e2c_pkg::S_YEAR) |-> (r_m100 < 7'd100 && r_m400 < 9'd400))
        else $error("year residues out of range");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == e2c_pkg::S_DHR) |-> (r_rem < 17'd86400))
        else $error("second of day out of range");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == e2c_pkg::S_DONE))
        else $error("result raised outside the final state");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    // base year after reset, kept here independently of the design
    localparam logic [11:0] RESET_BASE_YEAR = 12'd1970;
    localparam int unsigned SECS_DAY        = 86400;
    localparam int unsigned SECS_HOUR       = 3600;
    localparam int unsigned SECS_MIN        = 60;
    // settle time after the last word
    localparam int          SETTLE_CYCLES   = 250;
    localparam int          IDLE_PERCENT    = 7;
    localparam int          REPORT_LIMIT    = 10;

    // one calendar word as the output channel carries it
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_calendar;

    // an expected date, with what produced it for the mismatch report
    typedef struct {
        logic [31:0] secs;
        logic [11:0] base;
        t_calendar   date;
    } t_pending_date;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [11:0] i_cfg_wr_data   = 12'd0;
    logic        i_valid         = 1'b0;
    logic [31:0] i_epoch_seconds = 32'd0;
    logic        i_stall         = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    t_pending_date expected_dates[$];
    logic [11:0]   base_year_now = RESET_BASE_YEAR;   // predictor's copy of the register
    bit            steady        = 1'b0;              // no idling on either side when set
    int            fault_count   = 0;

    epoch_seconds_to_calendar dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    // Gregorian rule on the 12-bit year counter value
    function automatic bit leap_year(input logic [11:0] y);
        int unsigned v;
        v = 32'(y);
        return ((v % 4) == 0 && (v % 100) != 0) || (v % 400) == 0;
    endfunction

    function automatic int unsigned month_days(input logic [3:0] m, input bit leap);
        case (m)
            4'd2: begin
                return leap ? 29 : 28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    // time of day by plain division, then whole years, then months;
    // the year counter wraps at 12 bits and the month walk stops at December
    function automatic t_calendar predict_calendar(input logic [31:0] secs,
                                                   input logic [11:0] base);
        t_calendar   c;
        int unsigned days;
        int unsigned tod;
        int unsigned span;
        logic [11:0] yr;
        logic [3:0]  mon;
        tod      = secs % SECS_DAY;
        days     = secs / SECS_DAY;
        c.hour   = 5'(tod / SECS_HOUR);
        tod      = tod % SECS_HOUR;
        c.minute = 6'(tod / SECS_MIN);
        c.second = 6'(tod % SECS_MIN);
        yr   = base;
        span = leap_year(yr) ? 366 : 365;
        while (days >= span) begin
            days = days - span;
            yr   = yr + 12'd1;
            span = leap_year(yr) ? 366 : 365;
        end
        mon = 4'd1;
        while (mon < 4'd12) begin
            span = month_days(mon, leap_year(yr));
            if (days < span) begin
                break;
            end
            days = days - span;
            mon  = mon + 4'd1;
        end
        c.year  = yr;
        c.month = mon;
        c.day   = 5'(days + 1);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall and the result check
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        i_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // every word taken off the output is matched against the oldest expectation
    always @(posedge i_clk) begin : check_dates
        t_calendar     got;
        t_pending_date want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_year, o_month, o_day_of_month, o_hour, o_minute, o_second};
            if (expected_dates.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("unexpected word: %0d-%0d-%0d %0d:%0d:%0d",
                             got.year, got.month, got.day,
                             got.hour, got.minute, got.second);
                end
            end else begin
                want = expected_dates.pop_front();
                if (got !== want.date) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("mismatch: secs %0d base %0d want %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                                 want.secs, want.base,
                                 want.date.year, want.date.month, want.date.day,
                                 want.date.hour, want.date.minute, want.date.second,
                                 got.year, got.month, got.day,
                                 got.hour, got.minute, got.second);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side: shared tasks
    // ------------------------------------------------------------------

    // one word in; an occasional gap of varied length first so the next
    // word lands at all points of the output handshake
    task automatic send_seconds(input logic [31:0] secs);
        int  gap;
        bit  taken;
        @(negedge i_clk);
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            gap             = $urandom_range(1, 250);
            i_valid         = 1'b0;
            i_epoch_seconds = $urandom();
            repeat (gap) @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_epoch_seconds = secs;
        taken           = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
        end
        expected_dates.push_back('{secs: secs, base: base_year_now,
                                   date: predict_calendar(secs, base_year_now)});
    endtask

    // drop valid and wait until every date has come out
    task automatic drain_dates();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_dates.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // base year write, only with the block idle; every word yields a date,
    // so an empty queue means nothing is still in flight
    task automatic set_base_year(input logic [11:0] y);
        drain_dates();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = y;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 12'($urandom());
        base_year_now = y;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // register left at its reset value: time-of-day edges, field limits,
    // a leap day and the last second of a leap year
    task automatic test_reset_base();
        send_seconds(32'd0);
        send_seconds(32'd59);
        send_seconds(32'd60);
        send_seconds(32'd3599);
        send_seconds(32'd3600);
        send_seconds(32'd86399);
        send_seconds(32'd86400);
        send_seconds(32'hFFFF_FFFF);
        send_seconds(32'd951782400);             // 29 Feb 2000
        send_seconds(32'd951868800);             // 1 Mar 2000
        send_seconds(32'd1095 * SECS_DAY + 32'd86399);  // 31 Dec 1972, last second
        send_seconds(32'd31 * SECS_DAY - 32'd1); // end of January
    endtask

    // century years: 1900 and 2100 are not leap, 2000 is; also the case
    // where the day count runs out in December
    task automatic test_leap_rules();
        set_base_year(12'd1900);
        send_seconds(32'd58 * SECS_DAY);
        send_seconds(32'd59 * SECS_DAY);
        set_base_year(12'd2100);
        send_seconds(32'd58 * SECS_DAY);
        send_seconds(32'd59 * SECS_DAY);
        set_base_year(12'd2000);
        send_seconds(32'd59 * SECS_DAY);
        send_seconds(32'd366 * SECS_DAY - 32'd1);
        send_seconds(32'hFFFF_FFFF);
    endtask

    // base year outside the calendar range: counter wraps past 4095 to 0,
    // and year 0 counts as leap
    task automatic test_base_year_extremes();
        set_base_year(12'd0);
        send_seconds(32'd59 * SECS_DAY);
        send_seconds(32'hFFFF_FFFF);
        set_base_year(12'hFFF);
        send_seconds(32'd365 * SECS_DAY);
        send_seconds(32'd424 * SECS_DAY + 32'd43210);
    endtask

    // random words in phases, each with its own base year; one phase runs
    // with no idling on either side
    task automatic test_random_dates(input int phases, input int per_phase);
        logic [31:0] secs;
        logic [11:0] base;
        for (int p = 0; p < phases; p++) begin
            if ($urandom_range(0, 9) < 7) begin
                base = 12'($urandom_range(1900, 2100));
            end else begin
                base = 12'($urandom_range(0, 4095));
            end
            set_base_year(base);
            steady = (p == phases / 2);
            for (int n = 0; n < per_phase; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        secs = $urandom();
                    end
                    4, 5: begin
                        // within a few years of the base
                        secs = $urandom_range(0, 3 * 366 * SECS_DAY);
                    end
                    6, 7: begin
                        // first or last second of a day, or anywhere in it
                        secs = 32'($urandom_range(0, 49709)) * SECS_DAY;
                        case ($urandom_range(0, 2))
                            0: secs = secs;
                            1: secs = secs + 32'd86399;
                            default: secs = secs + $urandom_range(0, 86399);
                        endcase
                    end
                    8: begin
                        secs = 32'hFFFF_FFFF - $urandom_range(0, 400 * SECS_DAY);
                    end
                    default: begin
                        // close to a year boundary
                        secs = (32'($urandom_range(0, 135)) * 32'd365
                                + $urandom_range(0, 40)) * SECS_DAY
                               + ($urandom_range(0, 1) ? 32'd86399 : 32'd0);
                    end
                endcase
                send_seconds(secs);
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_base();
        test_leap_rules();
        test_base_year_extremes();
        test_random_dates(9, 100);

        drain_dates();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_dates.size() != 0) begin
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // a slow but correct run takes a few ms; this is well beyond it
    initial begin
        #(50_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/e2c_pkg.sv
hw/rtl/epoch_seconds_to_calendar.sv
test/tb_top.sv
